// ----- src/joystick_differential_drive_mixer_defines.svh -----
// Assertion macros for the verification code of the drive mixer.
`ifndef JOYSTICK_DIFFERENTIAL_DRIVE_MIXER_DEFINES_SVH
`define JOYSTICK_DIFFERENTIAL_DRIVE_MIXER_DEFINES_SVH

// Same-cycle implication, checked only while out of reset.
`define JDDM_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, also checked during reset.
`define JDDM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/jddm_pkg.sv -----
// Types and constants shared by the drive mixer and its checker.
`timescale 1ns / 1ps

package jddm_pkg;

    localparam int RAW_W      = 16;
    localparam int SPEED_W    = 17;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 17;
    localparam int S_TDATA_W  = 32;
    localparam int M_TDATA_W  = 40;
    localparam int STAGES     = 9;

    // Bit positions of the wheel speeds inside m_tdata.
    localparam int RIGHT_LSB = 0;
    localparam int LEFT_LSB  = SPEED_W;
    localparam int PAD_LSB   = 2 * SPEED_W;

    // Most negative code of a speed, which the mixer never produces.
    localparam logic [SPEED_W-1:0] SPEED_MIN_CODE = 17'h10000;

    // Expo weight of one in Q1.16.
    localparam logic [16:0] EXPO_ONE = 17'h10000;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CENTER_POSITION = 3'd0,
        REG_DEADZONE        = 3'd1,
        REG_EXPO_WEIGHT     = 3'd2,
        REG_TURN_GAIN       = 3'd3,
        REG_MAX_SPEED       = 3'd4
    } cfg_index_t;

    typedef struct packed {
        logic [15:0] center_position;
        logic [15:0] deadzone;
        logic [16:0] expo_weight;
        logic [15:0] turn_gain;
        logic [15:0] max_speed;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        center_position: 16'd32768,
        deadzone:        16'd1024,
        expo_weight:     17'd0,
        turn_gain:       16'd8192,
        max_speed:       16'd256
    };

endpackage

// ----- src/joystick_differential_drive_mixer.sv -----
// Arcade-drive mixer with expo curve: joystick sample in, two wheel speeds out.
//
// Input channel s_*: one request per joystick sample. s_tdata carries stick_x
// in bits 15:0 and stick_y in bits 31:16; s_tuser carries the brake flag.
// Output channel m_*: one request per sample, in the same order. m_tdata carries
// right_speed in bits 16:0 and left_speed in bits 33:17 (signed Q8.8), zeros above.
// Configuration is a plain write port (cfg_we, cfg_index, cfg_wdata) and must only
// be written while no sample is in flight.
//
// The work runs through nine register stages: centering and deadzone, square and
// linear term, cube, the two halves of the weighted cube, the expo sum, the speed
// scaling, the turn gain, the wheel sums with clamping, and the rounding stage
// that is also the output register. One sample enters every cycle unless a stalled
// receiver has filled the whole pipeline.
// Each stage holds its own valid bit and moves when the stage after it has room,
// so a stalled receiver fills empty stages first and s_tready only falls once the
// whole pipeline is full. Reset clears all valid bits and sets the configuration
// registers to their defaults; nothing is lost or repeated across a stall.
`timescale 1ns / 1ps

module joystick_differential_drive_mixer import jddm_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // stick_x[15:0], stick_y[31:16]
    input  logic [0:0]            s_tuser,   // brake[0]
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,   // right_speed[16:0], left_speed[33:17], zeros
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= CFG_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_CENTER_POSITION: cfg_reg.center_position <= cfg_wdata[15:0];
                REG_DEADZONE:        cfg_reg.deadzone        <= cfg_wdata[15:0];
                REG_EXPO_WEIGHT:     cfg_reg.expo_weight     <= cfg_wdata;
                REG_TURN_GAIN:       cfg_reg.turn_gain       <= cfg_wdata[15:0];
                REG_MAX_SPEED:       cfg_reg.max_speed       <= cfg_wdata[15:0];
                default: ;
            endcase
        end
    end

    // Weights above one act as one.
    logic [16:0] expo_e;
    logic [16:0] expo_rest;
    assign expo_e    = (cfg_reg.expo_weight > EXPO_ONE) ? EXPO_ONE : cfg_reg.expo_weight;
    assign expo_rest = EXPO_ONE - expo_e;

    // Valid bits and the ready chain.
    logic [STAGES:1] vld_reg;
    logic [STAGES:1] rdy;

    always_comb begin
        rdy[STAGES] = !vld_reg[STAGES] || m_tready;
        for (int k = STAGES - 1; k >= 1; k--) begin
            rdy[k] = !vld_reg[k] || rdy[k+1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            if (rdy[1]) begin
                vld_reg[1] <= s_tvalid;
            end
            for (int k = 2; k <= STAGES; k++) begin
                if (rdy[k]) begin
                    vld_reg[k] <= vld_reg[k-1];
                end
            end
        end
    end

    assign s_tready = rdy[1];

    // Axis 0 is x (steering), axis 1 is y (throttle).
    logic [1:0][RAW_W-1:0] raw;
    assign raw[0] = s_tdata[15:0];
    assign raw[1] = s_tdata[31:16];

    // Stage 1: center, saturate, magnitude, deadzone.
    logic [1:0][15:0] s1_mag_reg, s1_mag_next;
    logic [1:0]       s1_neg_reg, s1_neg_next;
    logic             s1_brake_reg;

    always_comb begin
        logic signed [16:0] diff;
        logic signed [16:0] diff_neg;
        for (int a = 0; a < 2; a++) begin
            diff     = signed'({1'b0, raw[a]}) - signed'({1'b0, cfg_reg.center_position});
            diff_neg = -diff;
            if (diff > 17'sd32767) begin
                s1_neg_next[a] = 1'b0;
                s1_mag_next[a] = 16'd32767;
            end else if (diff < -17'sd32768) begin
                s1_neg_next[a] = 1'b1;
                s1_mag_next[a] = 16'h8000;
            end else begin
                s1_neg_next[a] = diff[16];
                s1_mag_next[a] = diff[16] ? diff_neg[15:0] : diff[15:0];
            end
            if (s1_mag_next[a] < cfg_reg.deadzone) begin
                s1_mag_next[a] = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy[1]) begin
            s1_mag_reg   <= s1_mag_next;
            s1_neg_reg   <= s1_neg_next;
            s1_brake_reg <= s_tuser[0];
        end
    end

    // Stage 2: square of the magnitude and the linear term.
    logic [1:0][15:0] s2_mag_reg;
    logic [1:0][30:0] s2_sq_reg, s2_sq_next;
    logic [1:0][32:0] s2_lin_reg, s2_lin_next;
    logic [1:0]       s2_neg_reg;
    logic             s2_brake_reg;

    always_comb begin
        logic [31:0] sq;
        for (int a = 0; a < 2; a++) begin
            sq             = 32'(s1_mag_reg[a]) * 32'(s1_mag_reg[a]);
            s2_sq_next[a]  = sq[30:0];
            s2_lin_next[a] = 33'(expo_rest) * 33'(s1_mag_reg[a]);
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy[2]) begin
            s2_mag_reg   <= s1_mag_reg;
            s2_sq_reg    <= s2_sq_next;
            s2_lin_reg   <= s2_lin_next;
            s2_neg_reg   <= s1_neg_reg;
            s2_brake_reg <= s1_brake_reg;
        end
    end

    // Stage 3: cube of the magnitude.
    logic [1:0][45:0] s3_cube_reg, s3_cube_next;
    logic [1:0][32:0] s3_lin_reg;
    logic [1:0]       s3_neg_reg;
    logic             s3_brake_reg;

    always_comb begin
        logic [46:0] cube;
        for (int a = 0; a < 2; a++) begin
            cube            = 47'(s2_sq_reg[a]) * 47'(s2_mag_reg[a]);
            s3_cube_next[a] = cube[45:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy[3]) begin
            s3_cube_reg  <= s3_cube_next;
            s3_lin_reg   <= s2_lin_reg;
            s3_neg_reg   <= s2_neg_reg;
            s3_brake_reg <= s2_brake_reg;
        end
    end

    // Stage 4: weight times cube, as two partial products.
    logic [1:0][39:0] s4_plo_reg, s4_plo_next;
    logic [1:0][39:0] s4_phi_reg, s4_phi_next;
    logic [1:0][32:0] s4_lin_reg;
    logic [1:0]       s4_neg_reg;
    logic             s4_brake_reg;

    always_comb begin
        for (int a = 0; a < 2; a++) begin
            s4_plo_next[a] = 40'(expo_e) * 40'(s3_cube_reg[a][22:0]);
            s4_phi_next[a] = 40'(expo_e) * 40'(s3_cube_reg[a][45:23]);
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy[4]) begin
            s4_plo_reg   <= s4_plo_next;
            s4_phi_reg   <= s4_phi_next;
            s4_lin_reg   <= s3_lin_reg;
            s4_neg_reg   <= s3_neg_reg;
            s4_brake_reg <= s3_brake_reg;
        end
    end

    // Stage 5: blend sum, rounded half up to Q1.15, sign restored.
    logic signed [1:0][16:0] s5_v_reg, s5_v_next;
    logic                    s5_brake_reg;

    always_comb begin
        logic [63:0] acc;
        logic [16:0] mag;
        for (int a = 0; a < 2; a++) begin
            acc = 64'({s4_lin_reg[a], 30'b0}) + 64'(s4_plo_reg[a])
                + (64'(s4_phi_reg[a]) << 23) + (64'd1 << 45);
            mag = {1'b0, acc[61:46]};
            s5_v_next[a] = s4_neg_reg[a] ? -mag : mag;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy[5]) begin
            s5_v_reg     <= s5_v_next;
            s5_brake_reg <= s4_brake_reg;
        end
    end

    // Stage 6: both axes times max speed.
    logic signed [16:0] max_speed_s;
    logic signed [16:0] turn_gain_s;
    assign max_speed_s = signed'({1'b0, cfg_reg.max_speed});
    assign turn_gain_s = signed'({1'b0, cfg_reg.turn_gain});

    logic signed [1:0][33:0] s6_vm_reg, s6_vm_next;
    logic                    s6_brake_reg;

    always_comb begin
        logic signed [16:0] v;
        for (int a = 0; a < 2; a++) begin
            v             = s5_v_reg[a];
            s6_vm_next[a] = 34'(v) * 34'(max_speed_s);
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy[6]) begin
            s6_vm_reg    <= s6_vm_next;
            s6_brake_reg <= s5_brake_reg;
        end
    end

    // Stage 7: turn gain on x; throttle is y scaled by 2^14.
    logic signed [48:0] s7_turn_reg, s7_turn_next;
    logic signed [47:0] s7_thr_reg;
    logic               s7_brake_reg;

    always_comb begin
        logic signed [33:0] vxm;
        vxm          = s6_vm_reg[0];
        s7_turn_next = 49'(vxm) * 49'(turn_gain_s);
    end

    always_ff @(posedge aclk) begin
        if (rdy[7]) begin
            s7_turn_reg  <= s7_turn_next;
            s7_thr_reg   <= {s6_vm_reg[1], 14'b0};
            s7_brake_reg <= s6_brake_reg;
        end
    end

    // Stage 8: wheel sums clamped to plus or minus max speed.
    logic signed [46:0] s8_right_reg, s8_right_next;
    logic signed [46:0] s8_left_reg, s8_left_next;
    logic               s8_brake_reg;

    always_comb begin
        logic signed [49:0] thr;
        logic signed [49:0] trn;
        logic signed [49:0] lim;
        logic signed [49:0] rsum;
        logic signed [49:0] lsum;
        thr  = 50'(s7_thr_reg);
        trn  = 50'(s7_turn_reg);
        lim  = signed'({5'b0, cfg_reg.max_speed, 29'b0});
        rsum = thr - trn;
        lsum = thr + trn;
        if (rsum > lim) begin
            rsum = lim;
        end else if (rsum < -lim) begin
            rsum = -lim;
        end
        if (lsum > lim) begin
            lsum = lim;
        end else if (lsum < -lim) begin
            lsum = -lim;
        end
        s8_right_next = rsum[46:0];
        s8_left_next  = lsum[46:0];
    end

    always_ff @(posedge aclk) begin
        if (rdy[8]) begin
            s8_right_reg <= s8_right_next;
            s8_left_reg  <= s8_left_next;
            s8_brake_reg <= s7_brake_reg;
        end
    end

    // Stage 9: round to Q8.8 half away from zero; brake forces zero.
    logic [1:0][SPEED_W-1:0] s9_speed_reg, s9_speed_next;

    always_comb begin
        logic signed [46:0] c;
        logic        [46:0] absv;
        logic        [45:0] rnd;
        logic        [16:0] q;
        for (int w = 0; w < 2; w++) begin
            c    = (w == 0) ? s8_right_reg : s8_left_reg;
            absv = c[46] ? 47'(-c) : 47'(c);
            rnd  = absv[45:0] + (46'd1 << 28);
            q    = rnd[45:29];
            s9_speed_next[w] = s8_brake_reg ? '0 : (c[46] ? -q : q);
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy[9]) begin
            s9_speed_reg <= s9_speed_next;
        end
    end

    assign m_tvalid = vld_reg[STAGES];
    assign m_tdata  = {{(M_TDATA_W - PAD_LSB){1'b0}}, s9_speed_reg[1], s9_speed_reg[0]};

endmodule

// ----- src/jddm_checker.sv -----
// Port-level checker for the drive mixer, bound to the top level.
`timescale 1ns / 1ps
`include "joystick_differential_drive_mixer_defines.svh"

module jddm_checker import jddm_pkg::*; (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata
);

    // A waiting result stays and keeps its value.
    `JDDM_ASSERT_IMPL(a_out_hold, m_tvalid && !m_tready, ##1 (m_tvalid && $stable(m_tdata)), "result dropped or changed while stalled")

    // With the output free, the pipeline always has room for a request.
    `JDDM_ASSERT_IMPL(a_ready_when_free, !m_tvalid || m_tready, s_tready, "input stalled although the output can move")

    // Clamping and symmetric rounding never give the most negative code.
    `JDDM_ASSERT_IMPL(a_speed_range, m_tvalid, (m_tdata[RIGHT_LSB +: SPEED_W] != SPEED_MIN_CODE) && (m_tdata[LEFT_LSB +: SPEED_W] != SPEED_MIN_CODE), "wheel speed out of range")

    // Padding above the speeds is zero.
    `JDDM_ASSERT_IMPL(a_pad_zero, m_tvalid, m_tdata[M_TDATA_W-1:PAD_LSB] == '0, "nonzero padding in result")

    // Reset empties the pipeline.
    `JDDM_ASSERT_NEXT(a_reset_empty, !aresetn, !m_tvalid, "result valid right after reset")

endmodule

bind joystick_differential_drive_mixer jddm_checker u_jddm_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ----- dv/joystick_differential_drive_mixer_tb.sv -----
// Self-checking testbench for the joystick differential drive mixer.
`timescale 1ns / 1ps

module joystick_differential_drive_mixer_tb;
    import jddm_pkg::*;

    typedef struct packed {
        logic [15:0] stick_x;
        logic [15:0] stick_y;
        logic        brake;
    } stick_sample_t;

    typedef struct packed {
        logic [SPEED_W-1:0] right_speed;
        logic [SPEED_W-1:0] left_speed;
    } wheel_speeds_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;
    logic [0:0]            s_tuser   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    stick_sample_t samples_to_send[$];
    wheel_speeds_t wheel_speeds_due[$];
    cfg_t          mixer_regs = CFG_RESET;
    int            errors = 0;
    bit            s_taken = 1'b0;
    bit            sender_gaps_on = 1'b1;
    bit            receiver_stalls_on = 1'b1;
    int            burst_left = 0;
    int            gap_left = 0;
    int            ready_left = 0;
    int            stall_left = 0;

    joystick_differential_drive_mixer i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #4 aclk = ~aclk;

    // Centering, saturation, deadzone and expo curve of one axis, as Q1.15.
    function automatic longint shape_axis(logic [15:0] raw);
        longint               offset;
        longint unsigned      mag;
        longint unsigned      weight;
        longint unsigned      acc;
        bit                   neg;
        offset = longint'(raw) - longint'(mixer_regs.center_position);
        if (offset > 32767) offset = 32767;
        if (offset < -32768) offset = -32768;
        neg = offset < 0;
        mag = neg ? -offset : offset;
        if (mag < 64'(mixer_regs.deadzone)) mag = 0;
        weight = 64'((mixer_regs.expo_weight > EXPO_ONE) ? EXPO_ONE
                                                         : mixer_regs.expo_weight);
        acc = (((longint'(EXPO_ONE) - weight) * mag) << 30) + weight * mag * mag * mag;
        mag = (acc + (64'd1 << 45)) >> 46;
        return neg ? -longint'(mag) : longint'(mag);
    endfunction

    // Wheel sums are scaled by 2^-37; clamp to the speed limit, round to Q8.8.
    function automatic logic [SPEED_W-1:0] clamp_round_speed(longint sum);
        longint          limit;
        longint          rounded;
        longint unsigned mag;
        limit = longint'(mixer_regs.max_speed) << 29;
        if (sum > limit) sum = limit;
        if (sum < -limit) sum = -limit;
        mag = (sum < 0) ? -sum : sum;
        rounded = longint'((mag + (64'd1 << 28)) >> 29);
        if (sum < 0) rounded = -rounded;
        return rounded[SPEED_W-1:0];
    endfunction

    function automatic wheel_speeds_t predict_wheels(stick_sample_t smp);
        longint        steer;
        longint        throttle;
        longint        turn;
        wheel_speeds_t speeds;
        steer = shape_axis(smp.stick_x);
        throttle = shape_axis(smp.stick_y) * longint'(mixer_regs.max_speed) * 16384;
        turn = steer * longint'(mixer_regs.max_speed) * longint'(mixer_regs.turn_gain);
        if (smp.brake) begin
            speeds = '0;
        end else begin
            speeds.right_speed = clamp_round_speed(throttle - turn);
            speeds.left_speed = clamp_round_speed(throttle + turn);
        end
        return speeds;
    endfunction

    // Sender: bursts of requests, separated by random gaps while gaps are enabled.
    always @(negedge aclk) begin : sender
        stick_sample_t next_sample;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_taken) begin
            if (gap_left > 0 || samples_to_send.size() == 0) begin
                if (gap_left > 0) gap_left--;
                s_tvalid <= 1'b0;
            end else begin
                next_sample = samples_to_send.pop_front();
                s_tdata <= {next_sample.stick_y, next_sample.stick_x};
                s_tuser <= next_sample.brake;
                s_tvalid <= 1'b1;
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(0, 30);
                    if (!sender_gaps_on) gap_left = 0;
                    else if ($urandom_range(0, 4) == 0) gap_left = $urandom_range(5, 16);
                    else gap_left = $urandom_range(1, 3);
                end
            end
        end
    end

    // Receiver: runs of ready cycles with stalls in between while stalls are enabled,
    // some long enough to fill the pipeline.
    always @(negedge aclk) begin
        if (ready_left > 0) begin
            ready_left--;
            m_tready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else begin
            ready_left = $urandom_range(0, 24);
            if (!receiver_stalls_on) stall_left = 0;
            else if ($urandom_range(0, 3) == 0) stall_left = $urandom_range(10, 24);
            else stall_left = $urandom_range(1, 3);
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin : monitor
        wheel_speeds_t want;
        logic [SPEED_W-1:0] got_right;
        logic [SPEED_W-1:0] got_left;
        s_taken = 1'b0;
        if (!aresetn) begin
            mixer_regs = CFG_RESET;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    REG_CENTER_POSITION: mixer_regs.center_position = cfg_wdata[15:0];
                    REG_DEADZONE:        mixer_regs.deadzone = cfg_wdata[15:0];
                    REG_EXPO_WEIGHT:     mixer_regs.expo_weight = cfg_wdata[16:0];
                    REG_TURN_GAIN:       mixer_regs.turn_gain = cfg_wdata[15:0];
                    REG_MAX_SPEED:       mixer_regs.max_speed = cfg_wdata[15:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                s_taken = 1'b1;
                wheel_speeds_due.push_back(predict_wheels({s_tdata[15:0], s_tdata[31:16],
                                                           s_tuser[0]}));
            end
            if (m_tvalid && m_tready) begin
                got_right = m_tdata[RIGHT_LSB +: SPEED_W];
                got_left = m_tdata[LEFT_LSB +: SPEED_W];
                if (wheel_speeds_due.size() == 0) begin
                    $error("unexpected request: right_speed %0d, left_speed %0d",
                           $signed(got_right), $signed(got_left));
                    errors++;
                end else begin
                    want = wheel_speeds_due.pop_front();
                    if (got_right !== want.right_speed) begin
                        $error("right_speed: expected %0d, actual %0d",
                               $signed(want.right_speed), $signed(got_right));
                        errors++;
                    end
                    if (got_left !== want.left_speed) begin
                        $error("left_speed: expected %0d, actual %0d",
                               $signed(want.left_speed), $signed(got_left));
                        errors++;
                    end
                end
            end
        end
    end

    // Called at a falling edge; the caller lowers cfg_we after the last write.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(negedge aclk);
    endtask

    task automatic set_mixer(logic [16:0] center, logic [16:0] dead, logic [16:0] expo,
                             logic [16:0] gain, logic [16:0] speed);
        @(negedge aclk);
        write_reg(REG_CENTER_POSITION, center);
        write_reg(REG_DEADZONE, dead);
        write_reg(REG_EXPO_WEIGHT, expo);
        write_reg(REG_TURN_GAIN, gain);
        write_reg(REG_MAX_SPEED, speed);
        cfg_we <= 1'b0;
    endtask

    task automatic queue_sample(logic [15:0] x, logic [15:0] y, logic brake);
        samples_to_send.push_back('{stick_x: x, stick_y: y, brake: brake});
    endtask

    function automatic logic [15:0] random_axis(logic [15:0] center);
        case ($urandom_range(0, 3))
            0: return 16'($urandom_range(0, 65535));
            1: return center + 16'($urandom_range(0, 4096)) - 16'd2048;
            2: return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            default: return $urandom_range(0, 1) ? 16'($urandom_range(65000, 65535))
                                                : 16'($urandom_range(0, 535));
        endcase
    endfunction

    task automatic queue_random(int count);
        repeat (count) begin
            queue_sample(random_axis(mixer_regs.center_position),
                         random_axis(mixer_regs.center_position),
                         $urandom_range(0, 7) == 0);
        end
    endtask

    task automatic wait_drained();
        while (samples_to_send.size() != 0 || s_tvalid || wheel_speeds_due.size() != 0)
            @(posedge aclk);
        repeat (STAGES + 4) @(posedge aclk);
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Reset settings: axis extremes, the deadzone edges and braking.
        queue_sample(16'd32768, 16'd32768, 1'b0);
        queue_sample(16'd0, 16'd0, 1'b0);
        queue_sample(16'hFFFF, 16'hFFFF, 1'b0);
        queue_sample(16'd0, 16'hFFFF, 1'b0);
        queue_sample(16'hFFFF, 16'd0, 1'b0);
        queue_sample(16'd33791, 16'd32768, 1'b0);
        queue_sample(16'd33792, 16'd32768, 1'b0);
        queue_sample(16'd31744, 16'd31745, 1'b0);
        queue_sample(16'd32768, 16'd33792, 1'b0);
        queue_sample(16'd32768, 16'd31744, 1'b0);
        queue_sample(16'd31745, 16'd33791, 1'b0);
        queue_sample(16'hFFFF, 16'hFFFF, 1'b1);
        queue_sample(16'd0, 16'd0, 1'b1);
        queue_sample(16'd32768, 16'hFFFF, 1'b1);
        queue_random(30);
        wait_drained();

        // Extremes: every offset saturates or passes the deadzone, pure cube,
        // largest gain and speed limit.
        sender_gaps_on = 1'b0;
        set_mixer(17'd0, 17'd0, 17'h10000, 17'hFFFF, 17'hFFFF);
        queue_sample(16'hFFFF, 16'hFFFF, 1'b0);
        queue_sample(16'd0, 16'hFFFF, 1'b0);
        queue_random(40);
        wait_drained();

        // Weight above one, deadzone covering all but full negative saturation, zero speed limit.
        sender_gaps_on = 1'b1;
        receiver_stalls_on = 1'b0;
        set_mixer(17'hFFFF, 17'd32768, 17'h1FFFF, 17'd0, 17'd0);
        queue_sample(16'd0, 16'd0, 1'b0);
        queue_random(40);
        wait_drained();

        // Deadzone beyond the offset range; writes to unused indexes are ignored.
        receiver_stalls_on = 1'b1;
        set_mixer(17'd32768, 17'hFFFF, 17'd32768, 17'd16384, 17'd256);
        @(negedge aclk);
        for (int idx = int'(REG_MAX_SPEED) + 1; idx < 2 ** CFG_IDX_W; idx++)
            write_reg(CFG_IDX_W'(idx), CFG_DATA_W'($urandom));
        cfg_we <= 1'b0;
        queue_random(20);
        wait_drained();

        for (int phase = 0; phase < 6; phase++) begin
            sender_gaps_on = (phase % 3) != 1;
            receiver_stalls_on = (phase % 3) != 2;
            // Bit 16 of a 16-bit register's data is dropped by the block.
            set_mixer({1'($urandom_range(0, 1)), ($urandom_range(0, 3) == 0)
                          ? 16'($urandom_range(0, 65535))
                          : 16'($urandom_range(31768, 33768))},
                      {1'($urandom_range(0, 1)), 16'($urandom_range(0, 4096))},
                      ($urandom_range(0, 7) == 0) ? 17'($urandom_range(65537, 131071))
                                                  : 17'($urandom_range(0, 65536)),
                      {1'($urandom_range(0, 1)), 16'($urandom_range(0, 65535))},
                      {1'($urandom_range(0, 1)), ($urandom_range(0, 5) == 0)
                          ? 16'($urandom_range(0, 65535))
                          : 16'($urandom_range(1, 2048))});
            queue_random(55);
            wait_drained();
        end

        if (errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("status: fail");
        $finish;
    end

endmodule
